FILE: rtl/core/frs_pkg.sv
// Shared types and constants for the Fenwick range-sum engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package frs_pkg;

  localparam int SIZE_DEFAULT = 1024;

  localparam int SIZE_CFG_W = 11;
  localparam logic [SIZE_CFG_W-1:0] SIZE_CFG_RESET = 11'd1024;

  localparam int POS_W   = 10;
  localparam int DELTA_W = 32;
  localparam int TOTAL_W = 64;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_WALK,
    ST_DONE
  } frs_state_t;

endpackage

FILE: rtl/core/frs_node_ram.sv
// Single-port node memory for the Fenwick tree, registered read.
// Depends on frs_pkg for the node width.
`timescale 1ns / 1ps

module frs_node_ram #(
  parameter int SIZE = frs_pkg::SIZE_DEFAULT,
  parameter int AW   = $clog2(SIZE)
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic                         we,
  input  logic [AW-1:0]                addr,
  input  logic [frs_pkg::TOTAL_W-1:0]  wdata,
  output logic [frs_pkg::TOTAL_W-1:0]  rdata
);
  import frs_pkg::*;

  logic [TOTAL_W-1:0] mem [SIZE];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

FILE: rtl/core/frs_walker.sv
// Sequencer for the Fenwick tree: clearing pass, add walk (read-modify-write
// per node) and the two prefix walks of a query; holds the result register.
// Depends on frs_pkg; drives the port of frs_node_ram.
`timescale 1ns / 1ps

module frs_walker #(
  parameter int SIZE = frs_pkg::SIZE_DEFAULT,
  parameter int AW   = $clog2(SIZE),
  parameter int IW   = $clog2(SIZE + 1) + 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [IW-1:0]                n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         mode,
  input  logic [frs_pkg::POS_W-1:0]    position,
  input  logic signed [frs_pkg::DELTA_W-1:0] delta,
  input  logic [frs_pkg::POS_W-1:0]    range_low,
  input  logic [frs_pkg::POS_W-1:0]    range_high,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [frs_pkg::TOTAL_W-1:0] range_total,
  output logic                         ram_en,
  output logic                         ram_we,
  output logic [AW-1:0]                ram_addr,
  output logic [frs_pkg::TOTAL_W-1:0]  ram_wdata,
  input  logic [frs_pkg::TOTAL_W-1:0]  ram_rdata
);
  import frs_pkg::*;

  localparam int CW = (IW > POS_W + 1) ? IW : POS_W + 1;

  frs_state_t state, state_next;

  logic [IW-1:0]      idx;
  logic [IW-1:0]      lo_idx;
  logic [AW-1:0]      clr_addr;
  logic [TOTAL_W-1:0] delta_ext;
  logic [TOTAL_W-1:0] acc;
  logic               phase;     // 0: walk from high end, 1: walk below low end
  logic               pend;      // read data of last cycle's walk read is due
  logic               pend_sub;

  logic          accept;
  logic [CW-1:0] pos_ext, lo_ext, hi_ext, n_ext, hi_clamp;
  logic          add_ok, query_empty;
  logic [IW-1:0] idx_up, idx_down;
  logic          walk_issue;
  logic          out_load;

  assign accept   = in_valid && in_ready;
  assign pos_ext  = CW'(position);
  assign lo_ext   = CW'(range_low);
  assign hi_ext   = CW'(range_high);
  assign n_ext    = CW'(n);
  assign add_ok   = pos_ext < n_ext;
  assign hi_clamp = (hi_ext > n_ext - CW'(1)) ? n_ext - CW'(1) : hi_ext;
  assign query_empty = (n_ext == '0) || (lo_ext > hi_clamp);

  // parent on the add walk, next node on the prefix walk
  assign idx_up     = idx + (idx & (~idx + IW'(1)));
  assign idx_down   = idx & (idx - IW'(1));
  assign walk_issue = (idx != '0);
  assign out_load   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(SIZE - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (mode == MODE_ADD) begin
            state_next = add_ok ? ST_ADD_RD : ST_IDLE;
          end else begin
            state_next = query_empty ? ST_DONE : ST_WALK;
          end
        end
      end
      ST_ADD_RD: state_next = ST_ADD_WR;
      ST_ADD_WR: begin
        state_next = (idx_up <= n) ? ST_ADD_RD : ST_IDLE;
      end
      ST_WALK: begin
        if (!walk_issue && phase && !pend) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = AW'(idx - IW'(1));
    ram_wdata = ram_rdata + delta_ext;
    unique case (state)
      ST_CLEAR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_addr;
        ram_wdata = '0;
      end
      ST_IDLE:   in_ready = 1'b1;
      ST_ADD_RD: ram_en = 1'b1;
      ST_ADD_WR: begin
        ram_en = 1'b1;
        ram_we = 1'b1;
      end
      ST_WALK:   ram_en = walk_issue;
      ST_DONE:   ram_en = 1'b0;
      default:   ram_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      pend     <= 1'b0;
    end else begin
      if (state == ST_CLEAR) clr_addr <= clr_addr + AW'(1);
      pend <= (state == ST_WALK) && walk_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      idx       <= (mode == MODE_ADD) ? IW'(pos_ext + CW'(1)) : IW'(hi_clamp + CW'(1));
      lo_idx    <= IW'(lo_ext);
      delta_ext <= TOTAL_W'(delta);
      acc       <= '0;
      phase     <= 1'b0;
    end else if (state == ST_ADD_WR) begin
      idx <= idx_up;
    end else if (state == ST_WALK) begin
      if (walk_issue) begin
        idx <= idx_down;
      end else if (!phase) begin
        idx   <= lo_idx;
        phase <= 1'b1;
      end
      if (pend) acc <= pend_sub ? acc - ram_rdata : acc + ram_rdata;
    end
    pend_sub <= phase;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_load) range_total <= acc;
  end

`ifndef SYNTHESIS
  a_wr_after_rd: assert property (@(posedge clk) disable iff (rst)
    state == ST_ADD_WR |-> $past(state) == ST_ADD_RD)
    else $error("node write without preceding read");

  a_wr_same_node: assert property (@(posedge clk) disable iff (rst)
    state == ST_ADD_WR |-> ram_addr == $past(ram_addr))
    else $error("write-back address differs from read address");

  a_add_in_bounds: assert property (@(posedge clk) disable iff (rst)
    state == ST_ADD_RD |-> (idx != '0) && (idx <= n))
    else $error("add walk outside the tree");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result raised outside the done step");
`endif

endmodule

FILE: rtl/core/fenwick_range_sum_engine.sv
// Top level of the Fenwick range-sum engine: size register, node memory,
// walk sequencer. Depends on frs_pkg, frs_node_ram and frs_walker.
//
// Usage:
//   Input channel (in_valid/in_ready): mode 0 adds delta at position, mode 1
//   asks the sum over range_low..range_high. Adds give no result.
//   Output channel (out_valid/out_ready): one range_total per query.
//   Config channel (cfg_valid/cfg_ready, size_in_use): always ready; write
//   only while the engine is idle.
// Sequence:
//   An add reads, then writes back, each tree node on its upward walk
//   through the single memory port. A query is accepted, runs its two
//   prefix walks with a turnaround and a drain, and loads the result; an
//   empty range skips the walks. One item at a time.
// Reset: the node memory is cleared by a pass over all SIZE nodes, one
//   node per cycle, with in_ready low; config transfers are taken meanwhile.
// Stall: a finished result waits in the output register; the next item is
//   accepted, and a second result waits in the sequencer until it drains.
`timescale 1ns / 1ps

module fenwick_range_sum_engine #(
  parameter int SIZE = frs_pkg::SIZE_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [frs_pkg::SIZE_CFG_W-1:0]      size_in_use,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                mode,
  input  logic [frs_pkg::POS_W-1:0]           position,
  input  logic signed [frs_pkg::DELTA_W-1:0]  delta,
  input  logic [frs_pkg::POS_W-1:0]           range_low,
  input  logic [frs_pkg::POS_W-1:0]           range_high,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [frs_pkg::TOTAL_W-1:0]  range_total
);
  import frs_pkg::*;

  localparam int AW = $clog2(SIZE);
  localparam int IW = $clog2(SIZE + 1) + 1;
  localparam int ZW = (IW > SIZE_CFG_W) ? IW : SIZE_CFG_W;

  logic [SIZE_CFG_W-1:0] size_reg;
  logic [IW-1:0]         n;

  logic               ram_en, ram_we;
  logic [AW-1:0]      ram_addr;
  logic [TOTAL_W-1:0] ram_wdata, ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= SIZE_CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      size_reg <= size_in_use;
    end
  end

  // effective size, capped at SIZE nodes
  assign n = (ZW'(size_reg) > ZW'(SIZE)) ? IW'(SIZE) : IW'(size_reg);

  frs_walker #(
    .SIZE (SIZE),
    .AW   (AW),
    .IW   (IW)
  ) u_walker (
    .clk         (clk),
    .rst         (rst),
    .n           (n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .position    (position),
    .delta       (delta),
    .range_low   (range_low),
    .range_high  (range_high),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .range_total (range_total),
    .ram_en      (ram_en),
    .ram_we      (ram_we),
    .ram_addr    (ram_addr),
    .ram_wdata   (ram_wdata),
    .ram_rdata   (ram_rdata)
  );

  frs_node_ram #(
    .SIZE (SIZE),
    .AW   (AW)
  ) u_node_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule

FILE: bench/tb_fenwick_range_sum_engine.sv
// Self-checking bench for fenwick_range_sum_engine: point adds and range sums over
// several tree sizes, with random gaps on input and output. Depends on frs_pkg and
// the engine RTL; the expected sums come from a node array kept inside the bench.
`timescale 1ns / 1ps

module tb_fenwick_range_sum_engine;
  import frs_pkg::*;

  localparam int NODES = SIZE_DEFAULT;

  typedef struct {
    logic                      mode;
    logic [POS_W-1:0]          position;
    logic signed [DELTA_W-1:0] delta;
    logic [POS_W-1:0]          range_low;
    logic [POS_W-1:0]          range_high;
  } fw_item_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [SIZE_CFG_W-1:0]     size_in_use = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      mode = MODE_ADD;
  logic [POS_W-1:0]          position = '0;
  logic signed [DELTA_W-1:0] delta = '0;
  logic [POS_W-1:0]          range_low = '0;
  logic [POS_W-1:0]          range_high = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [TOTAL_W-1:0] range_total;

  fenwick_range_sum_engine u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .size_in_use(size_in_use),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .position   (position),
    .delta      (delta),
    .range_low  (range_low),
    .range_high (range_high),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .range_total(range_total)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mirror of the engine state
  logic [TOTAL_W-1:0]    node_sum [0:NODES];
  logic [SIZE_CFG_W-1:0] size_model = SIZE_CFG_RESET;
  logic [TOTAL_W-1:0]    sums_due [$];
  fw_item_t              pending [$];
  fw_item_t              shown;
  int                    error_count = 0;
  int                    send_pause = 0;
  int                    recv_stall = 0;
  bit                    calm = 1'b0;

  initial begin
    for (int k = 0; k <= NODES; k++) node_sum[k] = '0;
  end

  task automatic note_mismatch(input string what, input logic [TOTAL_W-1:0] want,
                               input logic [TOTAL_W-1:0] got);
    error_count++;
    $display("%0t ns: %s: expected %h, got %h", $realtime, what, want, got);
  endtask

  // Append one item to the driver's queue
  task automatic stage_item(input fw_item_t it);
    pending.insert(pending.size(), it);
  endtask

  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int unsigned live_size();
    return (size_model > NODES) ? NODES : size_model;
  endfunction

  function automatic logic [TOTAL_W-1:0] prefix_total(input int unsigned last);
    logic [TOTAL_W-1:0] acc;
    int unsigned        i;
    acc = '0;
    i = last + 1;
    while (i > 0 && i <= NODES) begin
      acc += node_sum[i];
      i -= i & (~i + 1);
    end
    return acc;
  endfunction

  // Apply one accepted transfer to the mirror; a query leaves its sum in sums_due.
  task automatic track_item(input fw_item_t it);
    int unsigned        n, i, hi;
    logic [TOTAL_W-1:0] acc;
    n = live_size();
    if (it.mode == MODE_ADD) begin
      if (it.position < n) begin
        i = it.position + 1;
        while (i <= n) begin
          node_sum[i] += {{(TOTAL_W-DELTA_W){it.delta[DELTA_W-1]}}, it.delta};
          i += i & (~i + 1);
        end
      end
    end else begin
      acc = '0;
      hi = it.range_high;
      if (n != 0) begin
        if (hi > n - 1) hi = n - 1;
        if (it.range_low <= hi) begin
          acc = prefix_total(hi);
          if (it.range_low > 0) acc -= prefix_total(it.range_low - 1);
        end
      end
      sums_due.insert(sums_due.size(), acc);
    end
  endtask

  // Input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      send_pause <= 0;
    end else begin
      if (in_valid && in_ready) track_item(shown);
      if (!in_valid || in_ready) begin
        if (send_pause != 0) begin
          in_valid   <= 1'b0;
          send_pause <= send_pause - 1;
        end else if (pending.size() != 0) begin
          shown = pending.pop_front();
          mode       <= shown.mode;
          position   <= shown.position;
          delta      <= shown.delta;
          range_low  <= shown.range_low;
          range_high <= shown.range_high;
          in_valid   <= 1'b1;
          send_pause <= pick_pause();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    logic [TOTAL_W-1:0] want;
    if (rst) begin
      out_ready  <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (sums_due.size() == 0) begin
          note_mismatch("range_total with no query outstanding", 'x, range_total);
        end else begin
          want = sums_due.pop_front();
          if (range_total !== want) note_mismatch("range_total", want, range_total);
        end
      end
      if (recv_stall != 0) begin
        out_ready  <= 1'b0;
        recv_stall <= recv_stall - 1;
      end else begin
        out_ready  <= 1'b1;
        recv_stall <= pick_pause();
      end
    end
  end

  function automatic fw_item_t add_item(input int unsigned pos,
                                        input logic signed [DELTA_W-1:0] d);
    fw_item_t it;
    it = '{MODE_ADD, POS_W'(pos), d, POS_W'($urandom), POS_W'($urandom)};
    return it;
  endfunction

  function automatic fw_item_t query_item(input int unsigned lo, input int unsigned hi);
    fw_item_t it;
    it = '{MODE_QUERY, POS_W'($urandom), DELTA_W'($urandom), POS_W'(lo), POS_W'(hi)};
    return it;
  endfunction

  function automatic fw_item_t random_item();
    fw_item_t    it;
    int unsigned top, r;
    top = (live_size() == 0) ? 0 : live_size() - 1;
    r = $urandom_range(0, 9);
    it.mode = ($urandom_range(0, 99) < 55) ? MODE_ADD : MODE_QUERY;
    // mostly in range; now and then anywhere, which covers ignored adds and clamping
    it.position = (r == 0) ? POS_W'($urandom) : POS_W'($urandom_range(0, top));
    case ($urandom_range(0, 7))
      0:       it.delta = 32'sh7FFF_FFFF;
      1:       it.delta = 32'sh8000_0000;
      2:       it.delta = DELTA_W'(int'($urandom_range(0, 16)) - 8);
      default: it.delta = DELTA_W'($urandom);
    endcase
    if (r == 1) begin
      it.range_low  = POS_W'($urandom);
      it.range_high = POS_W'($urandom);
    end else begin
      it.range_low  = POS_W'($urandom_range(0, top));
      it.range_high = POS_W'($urandom_range(it.range_low, top));
    end
    return it;
  endfunction

  task automatic write_size(input logic [SIZE_CFG_W-1:0] v);
    @(posedge clk);
    cfg_valid   <= 1'b1;
    size_in_use <= v;
    do @(posedge clk); while (!cfg_ready);
    size_model = v;
    cfg_valid  <= 1'b0;
  endtask

  // Adds give no result, so allow the last walk to finish after the final sum.
  task automatic drain();
    @(negedge clk);
    while (pending.size() != 0 || in_valid || sums_due.size() != 0) @(negedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_phase(input logic [SIZE_CFG_W-1:0] sz, input int count,
                              input bit quiet);
    write_size(sz);
    calm = quiet;
    @(negedge clk);
    repeat (count) stage_item(random_item());
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset size, extremes of positions and deltas, empty ranges
    @(negedge clk);
    stage_item(add_item(0, 32'sh7FFF_FFFF));
    stage_item(add_item(1023, 32'sh8000_0000));
    stage_item(add_item(511, -32'sd1));
    stage_item(add_item(512, 32'sd5));
    stage_item(query_item(0, 1023));
    stage_item(query_item(0, 0));
    stage_item(query_item(1023, 1023));
    stage_item(query_item(512, 511));
    stage_item(query_item(1023, 0));
    stage_item(query_item(0, 511));
    drain();

    // size zero: adds ignored, sums are zero
    write_size(11'd0);
    @(negedge clk);
    stage_item(add_item(0, 32'sd77));
    stage_item(query_item(0, 1023));
    drain();

    // size beyond the tree: treated as the full tree
    write_size(11'h7FF);
    @(negedge clk);
    stage_item(add_item(700, 32'sd9));
    stage_item(query_item(0, 1023));
    stage_item(query_item(700, 700));
    drain();

    // size one over a populated tree: no rebuild, end of range clamped
    write_size(11'd1);
    @(negedge clk);
    stage_item(add_item(0, -32'sd3));
    stage_item(add_item(1, 32'sd100));
    stage_item(query_item(0, 1023));
    stage_item(query_item(0, 0));
    stage_item(query_item(1, 1));
    drain();

    random_phase(11'd1024, 60, 1'b0);
    random_phase(11'd2, 30, 1'b0);
    random_phase(SIZE_CFG_W'($urandom_range(3, 1023)), 50, 1'b0);
    random_phase(11'd37, 50, 1'b1);
    random_phase(11'd0, 20, 1'b0);
    random_phase(11'h7FF, 50, 1'b0);
    random_phase(SIZE_CFG_W'($urandom_range(1025, 2046)), 40, 1'b0);
    random_phase(11'd1, 20, 1'b0);
    random_phase(11'd1024, 60, 1'b1);
    random_phase(11'd1024, 40, 1'b0);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
